>>> rtl/uat_pkg.sv
// shared constants, codes and control types for the unsorted array table
// depends on nothing; used by uat_ctrl, uat_dpath and unsorted_array_table
package uat_pkg;

   localparam int CAPACITY    = 128;
   localparam int VALUE_WIDTH = 8;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   // request codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NONE = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic start;   // request transfer, latch it and clear scan state
      logic exec;    // first cycle of the request
      logic scan;    // walk the entries
      logic load;    // move the result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       scan_done;
      logic       out_free;
   } sts_type;

endpackage

>>> rtl/unsorted_array_table.sv
// top level of the unsorted array table: sequencer plus datapath
// depends on uat_pkg, uat_ctrl and uat_dpath
//
// Compact unsorted list of up to 128 byte values with a fill count. A request
// is insert (append at the end, or status full when 128 entries are held),
// search (lowest matching index, or status not found) or delete (remove every
// occurrence and close the gaps, keeping the order of what stays). Each
// request gives exactly one result carrying the status, the index and the
// entry count after the request. One request is worked on at a time: insert
// and the unused request code load their result after the first cycle with
// no walk; search and delete load it once the walk through the entry memory
// has ended, at one entry per cycle over its single registered read port
// (a search that hits stops early). A load waits while the output register
// is still held by a stalled result. The next request can be taken the cycle
// after the load. The result sits in an output register, so the next request
// can be taken while it waits. After reset the list is empty and no clearing
// pass is needed.

module unsorted_array_table (
   input  logic       clock,
   input  logic       reset,

   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_value,

   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [6:0] rsp_index,
   output logic [7:0] rsp_count
);

   // command and status between sequencer and datapath
   uat_pkg::cmd_type cmd;
   uat_pkg::sts_type sts;

   // sequencer: idle, first cycle, scan, wait for the output register
   uat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: entry memory, fill count, scan pointers, output register
   uat_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_type   (req_type),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_index  (rsp_index),
      .rsp_count  (rsp_count)
   );

endmodule

>>> rtl/uat_ctrl.sv
// request sequencer for the unsorted array table
// depends on uat_pkg
module uat_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  uat_pkg::sts_type  sts,
   output uat_pkg::cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.op == uat_pkg::OP_SEARCH || sts.op == uat_pkg::OP_DELETE) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/uat_dpath.sv
// entry memory, fill count, scan pointers and output register of the table
// depends on uat_pkg
module uat_dpath (
   input  logic              clock,
   input  logic              reset,
   input  uat_pkg::cmd_type  cmd,
   output uat_pkg::sts_type  sts,
   input  logic [1:0]        req_type,
   input  logic [7:0]        req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [6:0]        rsp_index,
   output logic [7:0]        rsp_count
);

   localparam int AW = uat_pkg::ADDR_W;
   localparam int CW = uat_pkg::CNT_W;
   localparam int VW = uat_pkg::VALUE_WIDTH;

   logic [VW-1:0] mem [uat_pkg::CAPACITY];

   logic [1:0]    op_ff;
   logic [VW-1:0] val_ff;
   logic [CW-1:0] fill_ff;
   logic [CW-1:0] rd_idx_ff;
   logic          pend_ff;
   logic [AW-1:0] pidx_ff;
   logic [VW-1:0] rdata_ff;
   logic [CW-1:0] wr_ptr_ff;
   logic          hit_ff;
   logic [AW-1:0] first_ff;
   logic [1:0]    res_status_ff;
   logic [AW-1:0] res_index_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [6:0]    rsp_index_ff;
   logic [7:0]    rsp_count_ff;

   logic          is_search;
   logic          is_delete;
   logic          full;
   logic          issue;
   logic          match;
   logic          ins_we;
   logic          del_we;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [VW-1:0] mem_wdata;
   logic [1:0]    fin_status;
   logic [AW-1:0] fin_index;

   assign is_search = (op_ff == uat_pkg::OP_SEARCH);
   assign is_delete = (op_ff == uat_pkg::OP_DELETE);
   assign full      = (fill_ff >= CW'(uat_pkg::CAPACITY));

   // one read per cycle while entries remain; a search stops once it has a hit
   assign issue  = cmd.scan && (rd_idx_ff < fill_ff) && !(is_search && hit_ff);
   assign match  = pend_ff && (rdata_ff == val_ff);

   assign ins_we = cmd.exec && (op_ff == uat_pkg::OP_INSERT) && !full;
   assign del_we = cmd.scan && is_delete && pend_ff && !match;

   assign mem_we    = ins_we || del_we;
   assign mem_waddr = ins_we ? fill_ff[AW-1:0] : wr_ptr_ff[AW-1:0];
   assign mem_wdata = ins_we ? val_ff : rdata_ff;

   always_comb begin
      if (is_search || is_delete) begin
         fin_status = hit_ff ? uat_pkg::ST_OK : uat_pkg::ST_NONE;
         fin_index  = hit_ff ? first_ff : '0;
      end else begin
         fin_status = res_status_ff;
         fin_index  = res_index_ff;
      end
   end

   assign sts.op        = op_ff;
   assign sts.scan_done = !issue && !pend_ff;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (issue) begin
         rdata_ff <= mem[rd_idx_ff[AW-1:0]];
      end
   end

   // request and scan payload
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff     <= req_type;
         val_ff    <= req_value[VW-1:0];
         rd_idx_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         if (issue) begin
            rd_idx_ff <= rd_idx_ff + CW'(1);
            pidx_ff   <= rd_idx_ff[AW-1:0];
         end
         if (del_we) begin
            wr_ptr_ff <= wr_ptr_ff + CW'(1);
         end
      end
      if (cmd.scan && match && !hit_ff) begin
         first_ff <= pidx_ff;
      end
      if (cmd.exec) begin
         if (op_ff == uat_pkg::OP_INSERT && full) begin
            res_status_ff <= uat_pkg::ST_FULL;
            res_index_ff  <= '0;
         end else if (op_ff == uat_pkg::OP_INSERT) begin
            res_status_ff <= uat_pkg::ST_OK;
            res_index_ff  <= fill_ff[AW-1:0];
         end else begin
            res_status_ff <= uat_pkg::ST_OK;
            res_index_ff  <= '0;
         end
      end
      if (cmd.load) begin
         rsp_status_ff <= fin_status;
         rsp_index_ff  <= 7'(fin_index);
         rsp_count_ff  <= is_delete ? 8'(wr_ptr_ff) : 8'(fill_ff);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            pend_ff <= 1'b0;
            hit_ff  <= 1'b0;
         end else begin
            pend_ff <= issue;
            if (cmd.scan && match) begin
               hit_ff <= 1'b1;
            end
         end
         if (ins_we) begin
            fill_ff <= fill_ff + CW'(1);
         end else if (cmd.load && is_delete) begin
            fill_ff <= wr_ptr_ff;
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_count  = rsp_count_ff;

endmodule
